>>> sv/nsd_pkg.sv
// Shared declarations for the NMEA sentence deframer: line-length constant,
// status codes, character codes, result record, sentence lookup and hex digit helpers.
// No dependencies.
`timescale 1ns / 1ps

package nsd_pkg;

  // Longest line kept, start character included.
  localparam int LINE_MAX = 128;
  // Byte counter width: must be able to hold LINE_MAX itself.
  localparam int CNT_W    = $clog2(LINE_MAX + 1);
  localparam int NUM_TYPES = 12;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MALFORMED  = 3'd1,
    ST_MISMATCH   = 3'd2,
    ST_BAD_HEADER = 3'd3,
    ST_UNKNOWN    = 3'd4
  } nsd_status_t;

  typedef struct packed {
    nsd_status_t status;
    logic [15:0] talker_code;
    logic [3:0]  sentence_type;
    logic [7:0]  payload_length;
    logic [7:0]  computed_checksum;
    logic        started_with_bang;
  } nsd_result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } nsd_lookup_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } nsd_nibble_t;

  // RMC GGA VTG VHW HDT HDG MWV DPT DBT MTW XTE BWC, in index order.
  localparam logic [23:0] TYPE_CODES [NUM_TYPES] = '{
    24'h524D43, 24'h474741, 24'h565447, 24'h564857, 24'h484454, 24'h484447,
    24'h4D5756, 24'h445054, 24'h444254, 24'h4D5457, 24'h585445, 24'h425743
  };

  function automatic nsd_lookup_t nsd_find_type(input logic [23:0] code);
    nsd_lookup_t r;
    r = '0;
    for (int i = NUM_TYPES - 1; i >= 0; i--) begin
      if (TYPE_CODES[i] == code) begin
        r.hit = 1'b1;
        r.idx = 4'(i);
      end
    end
    return r;
  endfunction

  function automatic nsd_nibble_t nsd_hex_nibble(input logic [7:0] c);
    nsd_nibble_t r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r.value = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      r.value = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      r.value = 4'(c - 8'h57);
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> sv/nsd_linecore.sv
// Line state of the NMEA deframer: header capture, checksum accumulation and
// the end-of-line verdict. Depends on nsd_pkg.
`timescale 1ns / 1ps

module nsd_linecore (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          byte_data,
  output logic                res_valid,
  output nsd_pkg::nsd_result_t res
);

  typedef struct packed {
    logic                      in_line;
    logic [nsd_pkg::CNT_W-1:0] byte_count;
    logic [7:0]                xor_accum;
    logic                      star_seen;
    logic [nsd_pkg::CNT_W-1:0] star_offset;
    logic [1:0]                hex_digits_taken;
    logic [7:0]                received_checksum;
    logic                      hex_invalid;
    logic [15:0]               talker_bytes;
    logic [23:0]               sentence_bytes;
    logic                      comma_present;
    logic                      bang_start;
  } nsd_line_t;

  nsd_line_t             line_r;
  nsd_line_t             line_nxt;
  logic                  is_start;
  logic                  is_eol;
  logic [nsd_pkg::CNT_W:0] plen_ext;
  nsd_pkg::nsd_lookup_t  lookup;
  nsd_pkg::nsd_nibble_t  nib;
  logic [nsd_pkg::CNT_W-1:0] pos;

  assign is_start = (byte_data == nsd_pkg::CH_DOLLAR) || (byte_data == nsd_pkg::CH_BANG);
  assign is_eol   = (byte_data == nsd_pkg::CH_CR) || (byte_data == nsd_pkg::CH_LF);
  assign pos      = line_r.byte_count;
  assign nib      = nsd_pkg::nsd_hex_nibble(byte_data);
  assign lookup   = nsd_pkg::nsd_find_type(line_r.sentence_bytes);

  // Payload length runs up to the first star, or to the end when none came.
  assign plen_ext = line_r.star_seen
                  ? ({1'b0, line_r.star_offset} - (nsd_pkg::CNT_W + 1)'(1))
                  : ({1'b0, line_r.byte_count} - (nsd_pkg::CNT_W + 1)'(1));

  assign res_valid = byte_valid && !is_start && line_r.in_line && is_eol;

  always_comb begin
    res                   = '0;
    res.talker_code       = line_r.talker_bytes;
    res.computed_checksum = line_r.xor_accum;
    res.started_with_bang = line_r.bang_start;
    if (plen_ext > (nsd_pkg::CNT_W + 1)'(255)) begin
      res.payload_length = 8'hFF;
    end else begin
      res.payload_length = 8'(plen_ext);
    end
    if (!line_r.star_seen || (line_r.hex_digits_taken < 2'd2) || line_r.hex_invalid) begin
      res.status = nsd_pkg::ST_MALFORMED;
    end else if (line_r.received_checksum != line_r.xor_accum) begin
      res.status = nsd_pkg::ST_MISMATCH;
    end else if ((plen_ext < (nsd_pkg::CNT_W + 1)'(6)) || !line_r.comma_present) begin
      res.status = nsd_pkg::ST_BAD_HEADER;
    end else if (!lookup.hit) begin
      res.status = nsd_pkg::ST_UNKNOWN;
    end else begin
      res.status        = nsd_pkg::ST_OK;
      res.sentence_type = lookup.idx;
    end
  end

  always_comb begin
    line_nxt = line_r;
    if (byte_valid) begin
      if (is_start) begin
        line_nxt            = '0;
        line_nxt.in_line    = 1'b1;
        line_nxt.byte_count = nsd_pkg::CNT_W'(1);
        line_nxt.bang_start = (byte_data == nsd_pkg::CH_BANG);
      end else if (line_r.in_line) begin
        if (is_eol) begin
          line_nxt = '0;
        end else if (pos >= nsd_pkg::CNT_W'(nsd_pkg::LINE_MAX)) begin
          // Overlong line: dropped without a result.
          line_nxt = '0;
        end else begin
          if ((pos == nsd_pkg::CNT_W'(1)) || (pos == nsd_pkg::CNT_W'(2))) begin
            line_nxt.talker_bytes = {line_r.talker_bytes[7:0], byte_data};
          end else if ((pos >= nsd_pkg::CNT_W'(3)) && (pos <= nsd_pkg::CNT_W'(5))) begin
            line_nxt.sentence_bytes = {line_r.sentence_bytes[15:0], byte_data};
          end else if (pos == nsd_pkg::CNT_W'(6)) begin
            line_nxt.comma_present = (byte_data == nsd_pkg::CH_COMMA);
          end
          if (!line_r.star_seen) begin
            if (byte_data == nsd_pkg::CH_STAR) begin
              line_nxt.star_seen   = 1'b1;
              line_nxt.star_offset = pos;
            end else begin
              line_nxt.xor_accum = line_r.xor_accum ^ byte_data;
            end
          end else if (line_r.hex_digits_taken < 2'd2) begin
            line_nxt.hex_invalid       = line_r.hex_invalid | nib.bad;
            line_nxt.received_checksum = {line_r.received_checksum[3:0],
                                          nib.bad ? 4'd0 : nib.value};
            line_nxt.hex_digits_taken  = line_r.hex_digits_taken + 2'd1;
          end
          line_nxt.byte_count = pos + nsd_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
    end else begin
      line_r <= line_nxt;
    end
  end

endmodule

>>> sv/nmea_sentence_deframer.sv
// Top level of the NMEA 0183 sentence deframer and checksum checker.
// Depends on nsd_pkg and nsd_linecore.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake             Payload
//  in_       input      in_valid / in_stall   in_byte_in (one serial byte)
//  out_      output     out_valid / out_stall status, talker, type, length,
//                                             checksum, start character
//
// One byte is taken every cycle while in_stall is low. The line's closing CR or
// LF passes the input register, then the result register, before its result leaves.
// Reset (rst_n low at a clock edge) empties both registers and closes any line.
// While a result waits under out_stall, the input register can still take one
// byte; in_stall rises as soon as it holds a byte, whether or not that byte
// ends a line, and stays high until the result leaves.

module nmea_sentence_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [15:0] out_talker_code,
  output logic [3:0] out_sentence_type,
  output logic [7:0] out_payload_length,
  output logic [7:0] out_computed_checksum,
  output logic       out_started_with_bang
);

  // Input register: holds one byte until the line logic can consume it.
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_fire;
  logic       in_accept;

  // Result register.
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  nsd_pkg::nsd_result_t out_res_r;
  logic                 core_res_valid;
  nsd_pkg::nsd_result_t core_res;

  // The held byte must wait only when the result register is occupied and
  // stalled. Holding every byte in that case keeps line order trivially.
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign s1_fire   = s1_valid_r && !in_stall;

  assign s1_valid_nxt = in_stall ? 1'b1 : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_byte_in;
    end
  end

  nsd_linecore u_linecore (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (s1_fire),
    .byte_data  (s1_byte_r),
    .res_valid  (core_res_valid),
    .res        (core_res)
  );

  // When s1 fires, the result register is either empty or being drained.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && core_res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && core_res_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_res_r.status;
  assign out_talker_code       = out_res_r.talker_code;
  assign out_sentence_type     = out_res_r.sentence_type;
  assign out_payload_length    = out_res_r.payload_length;
  assign out_computed_checksum = out_res_r.computed_checksum;
  assign out_started_with_bang = out_res_r.started_with_bang;

  // An accepted sentence always carries a full header.
  a_ok_has_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == nsd_pkg::ST_OK)) |-> (out_payload_length >= 8'd6))
    else $error("accepted sentence with short payload");

  // The sentence index is only reported for accepted sentences.
  a_type_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != nsd_pkg::ST_OK)) |-> (out_sentence_type == 4'd0))
    else $error("sentence type set on a rejected line");

  // A line end consumed by the line logic shows up in the next cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && core_res_valid) |=> out_valid)
    else $error("line result lost");

endmodule

>>> dv/nmea_sentence_deframer_tb.sv
// Self-checking testbench for the NMEA 0183 sentence deframer.
// It builds a byte-level model of the line parser to predict each status record.
// It depends on nsd_pkg and nmea_sentence_deframer from the sv folder.
`timescale 1ns / 1ps

module nmea_sentence_deframer_tb;

  // Each side idles in roughly this many cycles out of a hundred.
  localparam int IDLE_PCT     = 6;
  // Length of the single long receiver hold-off, in clock cycles.
  localparam int HOLD_CYCLES  = 400;
  // Cycles allowed after the last expected result. The result path is two
  // registers deep, so this margin is ample.
  localparam int DRAIN_SETTLE = 8;
  // Random traffic keeps going until both of these counts are reached.
  localparam int RANDOM_BYTES = 40;
  localparam int RANDOM_LINES = 2;
  // Watchdog limit, far above the slowest correct run with the long hold-off.
  localparam int CYCLE_LIMIT  = 400000;

  // The sentence table, in result index order.
  localparam logic [23:0] KNOWN_CODES [12] = '{
    "RMC", "GGA", "VTG", "VHW", "HDT", "HDG",
    "MWV", "DPT", "DBT", "MTW", "XTE", "BWC"
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte_in;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [15:0] out_talker_code;
  logic [3:0]  out_sentence_type;
  logic [7:0]  out_payload_length;
  logic [7:0]  out_computed_checksum;
  logic        out_started_with_bang;

  nmea_sentence_deframer DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_byte_in            (in_byte_in),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_talker_code       (out_talker_code),
    .out_sentence_type     (out_sentence_type),
    .out_payload_length    (out_payload_length),
    .out_computed_checksum (out_computed_checksum),
    .out_started_with_bang (out_started_with_bang)
  );

  // Status records that the model has produced and the block still owes us,
  // oldest first.
  nsd_pkg::nsd_result_t expected_results[$];

  // Bytes of the sentence under construction. The stimulus tasks assemble a
  // whole line here and then push it out one transaction per byte.
  logic [7:0] line_buf[$];

  int  mismatches;
  int  lines_checked;
  int  lines_predicted;
  int  bytes_sent;
  int  cycle_count;
  bit  quiet_mode;
  bit  hold_request;

  // Line parser model state. A start character clears all of it.
  bit          line_open;
  int          held;
  logic [7:0]  running_xor;
  bit          star_hit;
  int          star_pos;
  int          digits_got;
  logic [7:0]  sent_sum;
  bit          digit_bad;
  logic [15:0] talker_q;
  logic [23:0] code_q;
  bit          comma_ok;
  bit          bang_q;

  // 50 MHz clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hang anywhere (lost result, stuck stall) ends here.
  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("nmea_sentence_deframer verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  function automatic void clear_line_state();
    line_open   = 1'b0;
    held        = 0;
    running_xor = '0;
    star_hit    = 1'b0;
    star_pos    = 0;
    digits_got  = 0;
    sent_sum    = '0;
    digit_bad   = 1'b0;
    talker_q    = '0;
    code_q      = '0;
    comma_ok    = 1'b0;
    bang_q      = 1'b0;
  endfunction

  // Advances the line parser model by one accepted byte. When the byte closes
  // a line, the status record that the block must produce is queued.
  function automatic void track_byte(input logic [7:0] b);
    nsd_pkg::nsd_result_t rec;
    int          plen;
    logic [3:0]  nib;
    if (b == nsd_pkg::CH_DOLLAR || b == nsd_pkg::CH_BANG) begin
      // A start character always opens a fresh line, even mid-line.
      clear_line_state();
      line_open = 1'b1;
      held      = 1;
      bang_q    = (b == nsd_pkg::CH_BANG);
      return;
    end
    if (!line_open) return;

    if (b == nsd_pkg::CH_CR || b == nsd_pkg::CH_LF) begin
      // The payload runs up to the first star, or to the line end without one.
      plen = star_hit ? star_pos - 1 : held - 1;
      rec  = '0;
      // Checksum problems are judged first, header problems only after the
      // checksum itself has been found correct.
      if (!star_hit || digits_got < 2 || digit_bad) begin
        rec.status = nsd_pkg::ST_MALFORMED;
      end else if (sent_sum != running_xor) begin
        rec.status = nsd_pkg::ST_MISMATCH;
      end else if (plen < 6 || !comma_ok) begin
        rec.status = nsd_pkg::ST_BAD_HEADER;
      end else begin
        rec.status = nsd_pkg::ST_UNKNOWN;
        for (int i = 0; i < 12; i++) begin
          if (rec.status == nsd_pkg::ST_UNKNOWN && KNOWN_CODES[i] == code_q) begin
            rec.status        = nsd_pkg::ST_OK;
            rec.sentence_type = 4'(i);
          end
        end
      end
      if (plen > 255) plen = 255;
      rec.talker_code       = talker_q;
      rec.payload_length    = 8'(plen);
      rec.computed_checksum = running_xor;
      rec.started_with_bang = bang_q;
      expected_results.push_back(rec);
      lines_predicted++;
      clear_line_state();
      return;
    end

    // One byte too many for the line buffer: the line vanishes without a record.
    if (held >= nsd_pkg::LINE_MAX) begin
      clear_line_state();
      return;
    end

    if (held == 1 || held == 2) talker_q = {talker_q[7:0], b};
    else if (held >= 3 && held <= 5) code_q = {code_q[15:0], b};
    else if (held == 6) comma_ok = (b == nsd_pkg::CH_COMMA);

    if (!star_hit) begin
      if (b == nsd_pkg::CH_STAR) begin
        star_hit = 1'b1;
        star_pos = held;
      end else begin
        running_xor ^= b;
      end
    end else if (digits_got < 2) begin
      // Hex digits in either case. Anything else marks the sum bad and
      // shifts in a zero nibble.
      nib = '0;
      if (b >= "0" && b <= "9") nib = 4'(b - 8'h30);
      else if (b >= "A" && b <= "F") nib = 4'(b - 8'h37);
      else if (b >= "a" && b <= "f") nib = 4'(b - 8'h57);
      else digit_bad = 1'b1;
      sent_sum = {sent_sum[3:0], nib};
      digits_got++;
    end
    held++;
  endfunction

  // Offers one byte and waits until the block takes it. Called at a falling
  // edge with nothing driven yet in that step, and it returns at a falling edge
  // with valid still high. An idle gap is only ever inserted before a byte is
  // offered, so a stalled payload never changes.
  task automatic send_byte(input logic [7:0] b);
    while (!quiet_mode && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drops valid for one cycle. This is the only place valid goes low outside
  // of the random idle gaps.
  task automatic sender_rest();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sender pause: waits until every predicted record has come out, then lets
  // the result pipeline settle so that a straggler would still be caught.
  task automatic wait_drained();
    sender_rest();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_SETTLE) @(negedge clk);
  endtask

  task automatic begin_line(input bit bang);
    line_buf.delete();
    line_buf.push_back(bang ? nsd_pkg::CH_BANG : nsd_pkg::CH_DOLLAR);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // XOR of every byte after the start character in the line buffer.
  function automatic logic [7:0] body_xor();
    logic [7:0] x;
    x = '0;
    for (int i = 1; i < line_buf.size(); i++) x ^= line_buf[i];
    return x;
  endfunction

  task automatic add_sum(input logic [7:0] sum, input bit lower);
    add_text(lower ? $sformatf("*%02x", sum) : $sformatf("*%02X", sum));
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  task automatic end_line();
    line_buf.push_back(nsd_pkg::CH_CR);
    send_line();
  endtask

  // A complete sentence ending in CR LF. A nonzero flip corrupts the sum.
  task automatic send_sentence(input bit bang, input string body, input bit lower,
                               input logic [7:0] flip);
    begin_line(bang);
    add_text(body);
    add_sum(body_xor() ^ flip, lower);
    line_buf.push_back(nsd_pkg::CH_CR);
    line_buf.push_back(nsd_pkg::CH_LF);
    send_line();
  endtask

  // Random payload character. Mostly printable ASCII, occasionally any value,
  // but never a character that would start, star or end the line.
  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
    else c = 8'($urandom_range(8'h20, 8'h7E));
    if (c == nsd_pkg::CH_DOLLAR || c == nsd_pkg::CH_BANG || c == nsd_pkg::CH_STAR ||
        c == nsd_pkg::CH_CR || c == nsd_pkg::CH_LF)
      c = nsd_pkg::CH_COMMA;
    return c;
  endfunction

  function automatic logic [7:0] random_letter();
    return 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  // Stray bytes, CR and LF with no line open, must never produce a record.
  task automatic test_outside_line();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(nsd_pkg::CH_CR);
    send_byte(nsd_pkg::CH_LF);
    send_byte(nsd_pkg::CH_STAR);
    send_byte("A");
  endtask

  // Every sentence type once, alternating the start character and varying talker and hex case.
  task automatic test_every_sentence_type();
    for (int i = 0; i < 12; i++) begin
      begin_line(i[0]);
      add_text(i[1] ? "GP" : "II");
      line_buf.push_back(KNOWN_CODES[i][23:16]);
      line_buf.push_back(KNOWN_CODES[i][15:8]);
      line_buf.push_back(KNOWN_CODES[i][7:0]);
      add_text($sformatf(",%0d", i));
      add_sum(body_xor(), i[2]);
      end_line();
    end
  endtask

  task automatic test_checksum_faults();
    // Missing star: the whole line after the start counts as payload.
    begin_line(1'b0);
    add_text("GPRMC,1");
    end_line();
    // Only one digit after the star.
    begin_line(1'b0);
    add_text("GPRMC,1*4");
    end_line();
    // A digit that is not hex.
    begin_line(1'b1);
    add_text("GPRMC,1*4Z");
    end_line();
    // Plain mismatch on a good header.
    send_sentence(1'b0, "GPGGA,2,3", 1'b0, 8'h01);
    // A bad sum outranks the header that is also too short here.
    send_sentence(1'b1, "GP", 1'b0, 8'h80);
    // Bytes after the two digits are ignored.
    begin_line(1'b0);
    add_text("GPVTG,5");
    add_sum(body_xor(), 1'b1);
    add_text("junk,");
    end_line();
  endtask

  task automatic test_header_faults();
    // Payload shorter than six bytes.
    send_sentence(1'b0, "GPRM", 1'b0, 8'h00);
    // No comma after the sentence code.
    send_sentence(1'b0, "GPRMCX1", 1'b0, 8'h00);
    // Unknown sentence code.
    send_sentence(1'b0, "GPXYZ,1", 1'b1, 8'h00);
    // Only one talker byte comes before the star.
    send_sentence(1'b1, "G", 1'b0, 8'h00);
    // A bare start character closed at once.
    begin_line(1'b1);
    end_line();
  endtask

  task automatic test_line_boundaries();
    // A new start character throws the partial line away.
    begin_line(1'b0);
    add_text("GPRMC,12");
    send_line();
    send_sentence(1'b0, "IIHDT,1", 1'b0, 8'h00);
    // LF alone closes a line too.
    begin_line(1'b1);
    add_text("AIMWV,9");
    add_sum(body_xor(), 1'b0);
    line_buf.push_back(nsd_pkg::CH_LF);
    send_line();
    // The smallest and largest byte values inside the payload.
    begin_line(1'b0);
    add_text("GPMTW,");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    add_sum(body_xor(), 1'b0);
    end_line();
    // Exactly LINE_MAX bytes before the CR: still kept.
    begin_line(1'b0);
    add_text("GPXTE,");
    while (line_buf.size() < nsd_pkg::LINE_MAX - 3) line_buf.push_back("7");
    add_sum(body_xor(), 1'b0);
    end_line();
    // One byte more: dropped, and the CR after it finds no line.
    begin_line(1'b0);
    add_text("GPXTE,");
    while (line_buf.size() < nsd_pkg::LINE_MAX - 2) line_buf.push_back("7");
    add_sum(body_xor(), 1'b0);
    end_line();
    send_sentence(1'b0, "GPBWC,3", 1'b0, 8'h00);
  endtask

  // One random line. Most are well-formed sentences with random content and
  // an occasional defect; the rest are raw noise and lines around the length limit.
  task automatic send_random_line();
    int          pick;
    int          n;
    int          defect;
    int          term;
    logic [23:0] code;
    logic [7:0]  sum;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // Noise covers every byte value, start characters and line ends included.
      n = $urandom_range(1, 12);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 11) begin
      // Around the length limit: some of these survive, some are dropped.
      begin_line($urandom_range(0, 1) == 1);
      n = $urandom_range(nsd_pkg::LINE_MAX - 3, nsd_pkg::LINE_MAX + 1);
      repeat (n) line_buf.push_back(filler_byte());
      end_line();
    end else begin
      begin_line($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) begin
        add_text("GP");
      end else begin
        line_buf.push_back(random_letter());
        line_buf.push_back(random_letter());
      end
      if ($urandom_range(0, 3) != 0) code = KNOWN_CODES[$urandom_range(0, 11)];
      else code = {random_letter(), random_letter(), random_letter()};
      line_buf.push_back(code[23:16]);
      line_buf.push_back(code[15:8]);
      line_buf.push_back(code[7:0]);
      line_buf.push_back(($urandom_range(0, 9) != 0) ? nsd_pkg::CH_COMMA : filler_byte());
      n = $urandom_range(0, 14);
      repeat (n) line_buf.push_back(filler_byte());
      // Now and then cut the header short.
      if ($urandom_range(0, 19) == 0) begin
        n = $urandom_range(1, 6);
        while (line_buf.size() > n) void'(line_buf.pop_back());
      end
      sum = body_xor();
      if ($urandom_range(0, 9) == 0) sum ^= 8'($urandom_range(1, 255));
      add_sum(sum, $urandom_range(0, 1) == 1);

      defect = $urandom_range(0, 19);
      case (defect)
        0: begin
          void'(line_buf.pop_back());
        end
        1: begin
          line_buf[line_buf.size() - 1] = filler_byte();
        end
        2: begin
          repeat (3) void'(line_buf.pop_back());
        end
        3: begin
          n = $urandom_range(1, 5);
          repeat (n) line_buf.push_back(filler_byte());
        end
        default: begin
        end
      endcase

      // An unterminated line is left for the next start character to discard.
      if (defect != 4) begin
        term = $urandom_range(0, 2);
        if (term != 1) line_buf.push_back(nsd_pkg::CH_CR);
        if (term != 0) line_buf.push_back(nsd_pkg::CH_LF);
      end
      send_line();
    end
  endtask

  // The receiver holds off for a long stretch while short sentences keep
  // coming, so the result and input registers fill and the input side must stall.
  task automatic test_output_hold();
    hold_request = 1'b1;
    for (int i = 0; i < 4; i++)
      send_sentence(i[0], $sformatf("GPDPT,%0d", i), 1'b0, 8'h00);
  endtask

  // Sender stops until everything is out, then resumes.
  task automatic test_pause_until_drained();
    send_sentence(1'b0, "GPHDG,10,1", 1'b0, 8'h00);
    send_sentence(1'b1, "GPVHW,,T", 1'b1, 8'h00);
    wait_drained();
    send_sentence(1'b0, "GPDBT,2", 1'b0, 8'h00);
  endtask

  // Back-to-back traffic with neither side idling.
  task automatic test_quiet_stretch();
    quiet_mode = 1'b1;
    repeat (4) send_random_line();
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_lines();
    int start_bytes;
    int start_lines;
    start_bytes = bytes_sent;
    start_lines = lines_predicted;
    while (bytes_sent - start_bytes < RANDOM_BYTES ||
           lines_predicted - start_lines < RANDOM_LINES)
      send_random_line();
  endtask

  // Receiver side. The hold-off is counted down here rather than in the
  // stimulus thread so that the sender keeps offering bytes during it.
  initial begin : receiver_stall
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_mode && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Every accepted status record is compared against the oldest prediction.
  always @(posedge clk) begin : result_check
    nsd_pkg::nsd_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected record, status %0d, length %0d",
                                  out_status, out_payload_length));
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("record %0d status: got %0d, expected %0d",
                                    lines_checked, out_status, want.status));
        if (out_talker_code !== want.talker_code)
          report_mismatch($sformatf("record %0d talker: got %h, expected %h",
                                    lines_checked, out_talker_code, want.talker_code));
        if (out_sentence_type !== want.sentence_type)
          report_mismatch($sformatf("record %0d type: got %0d, expected %0d",
                                    lines_checked, out_sentence_type, want.sentence_type));
        if (out_payload_length !== want.payload_length)
          report_mismatch($sformatf("record %0d length: got %0d, expected %0d",
                                    lines_checked, out_payload_length, want.payload_length));
        if (out_computed_checksum !== want.computed_checksum)
          report_mismatch($sformatf("record %0d checksum: got %h, expected %h",
                                    lines_checked, out_computed_checksum,
                                    want.computed_checksum));
        if (out_started_with_bang !== want.started_with_bang)
          report_mismatch($sformatf("record %0d start: got %0d, expected %0d",
                                    lines_checked, out_started_with_bang,
                                    want.started_with_bang));
      end
      lines_checked++;
    end
  end

  // Test sequence: reset, directed cases, pressure, random traffic, drain.
  initial begin
    mismatches      = 0;
    lines_checked   = 0;
    lines_predicted = 0;
    bytes_sent      = 0;
    quiet_mode      = 1'b0;
    hold_request    = 1'b0;
    clear_line_state();
    in_valid   = 1'b0;
    in_byte_in = '0;
    rst_n      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_outside_line();
    test_every_sentence_type();
    test_checksum_faults();
    test_header_faults();
    test_line_boundaries();
    test_output_hold();
    test_pause_until_drained();
    test_quiet_stretch();
    test_random_lines();

    wait_drained();
    if (mismatches == 0) begin
      $display("nmea_sentence_deframer verification clean");
    end else begin
      $display("nmea_sentence_deframer verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/nsd_pkg.sv
sv/nsd_linecore.sv
sv/nmea_sentence_deframer.sv
dv/nmea_sentence_deframer_tb.sv
